[src/oil_pkg.sv]
// Shared types, constants and controller/datapath command encodings for the ordered list.
package oil_pkg;

  // Default storage geometry.
  localparam int unsigned OIL_DEPTH       = 16;
  localparam int unsigned OIL_VALUE_WIDTH = 32;

  // Fixed widths of the beat fields.
  localparam int unsigned OIL_IN_VALUE_W  = 32;
  localparam int unsigned OIL_OUT_VALUE_W = 32;
  localparam int unsigned OIL_OUT_INDEX_W = 4;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_READOUT = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef struct packed {
    op_e                              op;
    logic signed [OIL_IN_VALUE_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    kind_e                             kind;
    logic signed [OIL_OUT_VALUE_W-1:0] entry_value;
    logic [OIL_OUT_INDEX_W-1:0]        entry_index;
    logic                              last;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_OUT_RD,
    ST_OUT_LOAD,
    ST_REJECT,
    ST_EMPTY
  } state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_TOP,
    IDX_ZERO,
    IDX_DEC,
    IDX_INC
  } idx_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC
  } cnt_op_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_VAL_ABOVE,
    WR_VAL_AT
  } wr_sel_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_ENTRY,
    OUT_FULL,
    OUT_EMPTY
  } out_sel_e;

  typedef struct packed {
    logic     capture;
    idx_op_e  idx_op;
    cnt_op_e  cnt_op;
    logic     ram_re;
    wr_sel_e  wr_sel;
    out_sel_e out_sel;
  } oil_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic ge;
    logic idx_zero;
    logic idx_last;
    logic out_free;
  } oil_status_t;

endpackage

[src/oil_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module oil_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/oil_dp.sv]
// Datapath of the ordered list: entry store, counters, operand and output register.
module oil_dp import oil_pkg::*; #(
  parameter int unsigned Depth      = OIL_DEPTH,
  parameter int unsigned ValueWidth = OIL_VALUE_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic signed [OIL_IN_VALUE_W-1:0] in_value_i,
  input  oil_cmd_t    cmd_i,
  output oil_status_t status_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_beat_t   out_data_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [ValueWidth-1:0] value_q;
  logic [ValueWidth-1:0] rdata;
  logic                  out_valid_q, out_valid_d;
  out_beat_t             out_q, out_d;

  logic [ValueWidth+OIL_IN_VALUE_W-1:0]  value_sx;
  logic [CW-1:0]                         count_m1;
  logic [AW-1:0]                         idx_p1;
  logic [CW-1:0]                         idx_p1_wide;
  logic                                  we;
  logic [AW-1:0]                         waddr;
  logic [ValueWidth-1:0]                 wdata;
  logic [ValueWidth+OIL_OUT_VALUE_W-1:0] rdata_zx;
  logic [AW+OIL_OUT_INDEX_W-1:0]         idx_zx;

  // Sign-extend the input value, then keep the storage width.
  assign value_sx = {{ValueWidth{in_value_i[OIL_IN_VALUE_W-1]}}, in_value_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      value_q <= value_sx[ValueWidth-1:0];
    end
  end

  assign count_m1    = count_q - CW'(1);
  assign idx_p1      = idx_q + AW'(1);
  assign idx_p1_wide = CW'(idx_q) + CW'(1);

  always_comb begin
    count_d = count_q;
    unique case (cmd_i.cnt_op)
      CNT_CLEAR: count_d = '0;
      CNT_INC:   count_d = count_q + CW'(1);
      default:   count_d = count_q;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    unique case (cmd_i.idx_op)
      IDX_TOP:  idx_d = count_m1[AW-1:0];
      IDX_ZERO: idx_d = '0;
      IDX_DEC:  idx_d = idx_q - AW'(1);
      IDX_INC:  idx_d = idx_p1;
      default:  idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    we    = 1'b1;
    waddr = idx_p1;
    wdata = value_q;
    unique case (cmd_i.wr_sel)
      WR_SHIFT: begin
        waddr = idx_p1;
        wdata = rdata;
      end
      WR_VAL_ABOVE: begin
        waddr = idx_p1;
        wdata = value_q;
      end
      WR_VAL_AT: begin
        waddr = idx_q;
        wdata = value_q;
      end
      default: we = 1'b0;
    endcase
  end

  oil_ram #(
    .Width(ValueWidth),
    .Depth(Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.ram_re),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // Output register: one beat of slack between the list and the consumer.
  assign rdata_zx = {{OIL_OUT_VALUE_W{1'b0}}, rdata};
  assign idx_zx   = {{OIL_OUT_INDEX_W{1'b0}}, idx_q};

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (cmd_i.out_sel)
      OUT_ENTRY: begin
        out_valid_d       = 1'b1;
        out_d.kind        = KIND_ENTRY;
        out_d.entry_value = rdata_zx[OIL_OUT_VALUE_W-1:0];
        out_d.entry_index = idx_zx[OIL_OUT_INDEX_W-1:0];
        out_d.last        = (count_q == idx_p1_wide);
      end
      OUT_FULL: begin
        out_valid_d = 1'b1;
        out_d       = '{kind: KIND_FULL, entry_value: '0, entry_index: '0, last: 1'b1};
      end
      OUT_EMPTY: begin
        out_valid_d = 1'b1;
        out_d       = '{kind: KIND_EMPTY, entry_value: '0, entry_index: '0, last: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.count_zero = (count_q == '0);
  assign status_o.full       = (count_q == CW'(Depth));
  assign status_o.ge         = ($signed(rdata) >= $signed(value_q));
  assign status_o.idx_zero   = (idx_q == '0);
  assign status_o.idx_last   = (count_q == idx_p1_wide);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

[src/oil_ctrl.sv]
// Controller state machine that sequences inserts, readouts and clears.
module oil_ctrl import oil_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  op_e         in_op_i,
  output logic        in_ready_o,
  input  oil_status_t status_i,
  output oil_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_op_i)
            OP_INSERT: begin
              if (status_i.full) begin
                state_d = ST_REJECT;
              end else if (status_i.count_zero) begin
                state_d = ST_INS_PUT;
              end else begin
                state_d = ST_INS_RD;
              end
            end
            OP_READOUT: state_d = status_i.count_zero ? ST_EMPTY : ST_OUT_RD;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_INS_RD: state_d = ST_INS_CMP;
      ST_INS_CMP: begin
        if (!status_i.ge) begin
          state_d = ST_IDLE;
        end else if (status_i.idx_zero) begin
          state_d = ST_INS_PUT;
        end else begin
          state_d = ST_INS_RD;
        end
      end
      ST_INS_PUT: state_d = ST_IDLE;
      ST_OUT_RD:  state_d = ST_OUT_LOAD;
      ST_OUT_LOAD: begin
        if (status_i.out_free) begin
          state_d = status_i.idx_last ? ST_IDLE : ST_OUT_RD;
        end
      end
      ST_REJECT, ST_EMPTY: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '{capture: 1'b0, idx_op: IDX_HOLD, cnt_op: CNT_HOLD, ram_re: 1'b0,
                   wr_sel: WR_NONE, out_sel: OUT_NONE};
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          unique case (in_op_i)
            OP_INSERT:  cmd_o.idx_op = status_i.count_zero ? IDX_ZERO : IDX_TOP;
            OP_READOUT: cmd_o.idx_op = IDX_ZERO;
            OP_CLEAR:   cmd_o.cnt_op = CNT_CLEAR;
            default:    ;
          endcase
        end
      end
      ST_INS_RD: cmd_o.ram_re = 1'b1;
      ST_INS_CMP: begin
        if (!status_i.ge) begin
          cmd_o.wr_sel = WR_VAL_ABOVE;
          cmd_o.cnt_op = CNT_INC;
        end else begin
          cmd_o.wr_sel = WR_SHIFT;
          if (!status_i.idx_zero) begin
            cmd_o.idx_op = IDX_DEC;
          end
        end
      end
      ST_INS_PUT: begin
        cmd_o.wr_sel = WR_VAL_AT;
        cmd_o.cnt_op = CNT_INC;
      end
      ST_OUT_RD: cmd_o.ram_re = 1'b1;
      ST_OUT_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.out_sel = OUT_ENTRY;
          if (!status_i.idx_last) begin
            cmd_o.idx_op = IDX_INC;
          end
        end
      end
      ST_REJECT: begin
        if (status_i.out_free) begin
          cmd_o.out_sel = OUT_FULL;
        end
      end
      ST_EMPTY: begin
        if (status_i.out_free) begin
          cmd_o.out_sel = OUT_EMPTY;
        end
      end
      default: ;
    endcase
  end

endmodule

[src/ordered_insertion_list.sv]
// Insert: each stored entry at or above the new value is read, compared and moved up; clear resets the count.
// Readout: each entry is one read of the entry RAM, loaded once the output register is free.
// Full-list reject and empty readout: one result beat each.
// Items are taken one at a time; a result beat waits in the output register while the next
// item is accepted. Reset empties the list at once; the entry RAM itself is not cleared.
// Top level of the ordered insertion list.
module ordered_insertion_list import oil_pkg::*; #(
  parameter int unsigned DEPTH       = OIL_DEPTH,
  parameter int unsigned VALUE_WIDTH = OIL_VALUE_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  // The controller and the datapath talk only through these two bundles.
  oil_cmd_t    cmd;
  oil_status_t status;

  // The controller walks the list from the top entry down on an insert, moving each
  // entry that is greater than or equal to the new value up by one place, and writes
  // the new value into the gap it leaves. A readout walks the list from the bottom up.
  oil_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the entry RAM, the entry count, the walk index, the captured
  // operand and the output beat register.
  oil_dp #(
    .Depth      (DEPTH),
    .ValueWidth (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_value_i  (in_data_i.value),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
